// ----- rtl/core/rbt_pkg.sv -----
// Shared types and constants of the reorder buffer tracker.
package rbt_pkg;

    localparam int TAG_W       = 6;
    localparam int TAG_SPAN    = 64;
    localparam int DEST_W      = 8;
    localparam int SEQ_W       = 32;
    localparam int PAYLOAD_W   = DEST_W + SEQ_W;
    localparam int BE_W        = 7;
    localparam int GW_W        = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [1:0] FUNC_ALLOC     = 2'd0;
    localparam logic [1:0] FUNC_WRITEBACK = 2'd1;
    localparam logic [1:0] FUNC_RETIRE    = 2'd2;
    localparam logic [1:0] FUNC_PEEK      = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_ENTRIES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_WIDTH    = 1'd1;

    localparam logic [BE_W-1:0] BUFFER_ENTRIES_RESET = 7'd64;
    localparam logic [GW_W-1:0] GROUP_WIDTH_RESET    = 4'd4;

    typedef struct packed {
        logic [1:0]              func;
        logic [TAG_W-1:0]        entry_tag;
        logic signed [DEST_W-1:0] dest_reg;
        logic [SEQ_W-1:0]        sequence_no;
    } rbt_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]         alloc_index;
        logic                     alloc_overflow;
        logic                     tag_ready;
        logic signed [DEST_W-1:0] tag_dest;
        logic [SEQ_W-1:0]         tag_sequence;
        logic                     group_free;
    } rbt_result_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic scan;
    } rbt_cmd_t;

    typedef struct packed {
        logic scan_done;
    } rbt_status_t;

endpackage

// ----- rtl/core/reorder_buffer_tracker_core.sv -----
// Top level of the reorder buffer tracker: controller, datapath and ports.
//
// Command channel: an item beat is taken at a rising edge with start high and
// busy low. func selects allocate, writeback, retire or peek; entry_tag picks
// the entry that tag_ready, tag_dest and tag_sequence report on.
// Result channel: done is high for exactly one cycle and result holds the beat
// until the next beat is written; the receiver cannot hold results off.
// Config channel: cfg_ready is always high; a beat with cfg_valid writes
// cfg_index 0 (buffer entries in use) or 1 (group width). Write it only while
// the block is idle.
// Sequence: after the accept edge, the write step updates tail, valid bits
// and the entry stores; then the free scan walks the valid bits from the
// tail, one entry per cycle, and stops at the first valid entry or after
// group_width entries (at most MAX_GROUP_WIDTH); then done rises. A new
// beat is taken in the done cycle itself.
// Reset: valid bits and tail clear at once, size returns to 64 and group
// width to 4; no clearing pass is needed, so start is taken right away.
module reorder_buffer_tracker_core
    import rbt_pkg::*;
#(
    parameter int BUFFER_DEPTH    = 64,
    parameter int MAX_GROUP_WIDTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rbt_item_t              item,
    output logic                   done,
    output rbt_result_t            result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    rbt_cmd_t    cmd;
    rbt_status_t status;

    // config beats are always taken
    assign cfg_ready = 1'b1;

    rbt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rbt_datapath #(
        .BUFFER_DEPTH    (BUFFER_DEPTH),
        .MAX_GROUP_WIDTH (MAX_GROUP_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- rtl/core/rbt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/rbt_ctrl.sv -----
// Sequencing state machine of the reorder buffer tracker.
module rbt_ctrl
    import rbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  rbt_status_t status,
    output rbt_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WRITE = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        cmd.scan    = 1'b0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                busy = 1'b0;
                done = 1'b1;
                // take the next beat while the result is on the ports
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WRITE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/rbt_datapath.sv -----
// Datapath: config registers, valid bits, tail, entry stores and free scan.
module rbt_datapath
    import rbt_pkg::*;
#(
    parameter int BUFFER_DEPTH    = 64,
    parameter int MAX_GROUP_WIDTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rbt_cmd_t               cmd,
    output rbt_status_t            status,
    input  rbt_item_t              item,
    output rbt_result_t            result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int SZ_W   = (CNT_W > BE_W) ? CNT_W : BE_W;
    localparam int GCNT_W = $clog2(MAX_GROUP_WIDTH + 1);
    localparam int GC_W   = (GCNT_W > GW_W) ? GCNT_W : GW_W;

    function automatic logic [TAG_SPAN*IDX_W-1:0] build_tag_map();
        logic [TAG_SPAN*IDX_W-1:0] map;
        map = '0;
        for (int i = 0; i < TAG_SPAN; i++)
        begin
            map[i*IDX_W +: IDX_W] = IDX_W'(i % BUFFER_DEPTH);
        end
        return map;
    endfunction

    localparam logic [TAG_SPAN*IDX_W-1:0] TAG_MAP = build_tag_map();

    function automatic logic [IDX_W-1:0] next_index(
        input logic [IDX_W-1:0] idx,
        input logic [SZ_W-1:0]  size
    );
        logic [SZ_W:0] inc;
        inc = (SZ_W+1)'(idx) + 1'b1;
        if (inc >= {1'b0, size})
        begin
            return '0;
        end
        return inc[IDX_W-1:0];
    endfunction

    logic [BE_W-1:0]  buffer_entries_reg;
    logic [GW_W-1:0]  group_width_reg;
    logic [1:0]       op_reg;
    logic [IDX_W-1:0] tag_reg;
    logic [PAYLOAD_W-1:0] payload_hold_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [GCNT_W-1:0] cnt_reg;
    logic [BUFFER_DEPTH-1:0] valid_reg;
    logic [TAG_W-1:0] alloc_index_reg;
    logic             overflow_reg;
    logic             group_free_reg;

    logic [SZ_W-1:0]   size_in_use;
    logic [SZ_W-1:0]   be_ext;
    logic [GC_W-1:0]   gw_ext;
    logic [GCNT_W-1:0] group_limit;
    logic              is_alloc;
    logic              is_wb;
    logic [IDX_W-1:0]  tail_next_idx;
    logic [IDX_W-1:0]  pos_next_idx;
    logic              count_met;

    logic                 ready_we;
    logic [IDX_W-1:0]     ready_addr;
    logic [0:0]           ready_rd;
    logic [PAYLOAD_W-1:0] payload_rd;

    // clamp the configured size and group width into their legal ranges
    assign be_ext = SZ_W'(buffer_entries_reg);
    always_comb
    begin
        if (be_ext == '0)
        begin
            size_in_use = SZ_W'(1);
        end
        else if (be_ext > SZ_W'(BUFFER_DEPTH))
        begin
            size_in_use = SZ_W'(BUFFER_DEPTH);
        end
        else
        begin
            size_in_use = be_ext;
        end
    end

    assign gw_ext      = GC_W'(group_width_reg);
    assign group_limit = (gw_ext > GC_W'(MAX_GROUP_WIDTH)) ? GCNT_W'(MAX_GROUP_WIDTH)
                                                           : GCNT_W'(gw_ext);

    assign is_alloc      = (op_reg == FUNC_ALLOC);
    assign is_wb         = (op_reg == FUNC_WRITEBACK);
    assign tail_next_idx = next_index(tail_reg, size_in_use);
    assign pos_next_idx  = next_index(pos_reg, size_in_use);
    assign count_met     = (cnt_reg >= group_limit);

    assign status.scan_done = count_met || valid_reg[pos_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_entries_reg <= BUFFER_ENTRIES_RESET;
            group_width_reg    <= GROUP_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUFFER_ENTRIES: buffer_entries_reg <= cfg_data[BE_W-1:0];
                CFG_GROUP_WIDTH:    group_width_reg    <= cfg_data[GW_W-1:0];
                default:            ;
            endcase
        end
    end

    // control state: tail pointer, valid bits, scan walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg  <= '0;
            valid_reg <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            cnt_reg <= '0;
            if (is_alloc)
            begin
                valid_reg[tail_reg] <= 1'b1;
                tail_reg            <= tail_next_idx;
                pos_reg             <= tail_next_idx;
            end
            else
            begin
                pos_reg <= tail_reg;
                if (op_reg == FUNC_RETIRE)
                begin
                    valid_reg[tag_reg] <= 1'b0;
                end
            end
        end
        else if (cmd.scan && !status.scan_done)
        begin
            pos_reg <= pos_next_idx;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg           <= item.func;
            tag_reg          <= TAG_MAP[int'(item.entry_tag)*IDX_W +: IDX_W];
            payload_hold_reg <= {item.dest_reg, item.sequence_no};
        end
        if (cmd.commit)
        begin
            alloc_index_reg <= is_alloc ? TAG_W'(tail_reg) : '0;
            overflow_reg    <= is_alloc && valid_reg[tail_reg];
        end
        if (cmd.scan && status.scan_done)
        begin
            group_free_reg <= count_met;
        end
    end

    assign ready_we   = cmd.commit && (is_alloc || is_wb);
    assign ready_addr = is_alloc ? tail_reg : tag_reg;

    rbt_ram #(
        .WIDTH (1),
        .DEPTH (BUFFER_DEPTH)
    ) u_ready_ram (
        .clk     (clk),
        .we      (ready_we),
        .wr_addr (ready_addr),
        .wr_data (is_wb),
        .rd_en   (cmd.scan),
        .rd_addr (tag_reg),
        .rd_data (ready_rd)
    );

    rbt_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .we      (cmd.commit && is_alloc),
        .wr_addr (tail_reg),
        .wr_data (payload_hold_reg),
        .rd_en   (cmd.scan),
        .rd_addr (tag_reg),
        .rd_data (payload_rd)
    );

    assign result.alloc_index    = alloc_index_reg;
    assign result.alloc_overflow = overflow_reg;
    assign result.tag_ready      = ready_rd[0];
    assign result.tag_dest       = payload_rd[PAYLOAD_W-1:SEQ_W];
    assign result.tag_sequence   = payload_rd[SEQ_W-1:0];
    assign result.group_free     = group_free_reg;

endmodule
